// ===== hw/rtl/trx_pkg.sv =====
// trx_pkg: request/response types, command and opcode codes, register file init values
// shared by the execute core top level and its bench; depends on nothing
`default_nettype none

package trx_pkg;

  localparam int RegCount = 32;
  localparam int RegIdxW  = 5;

  typedef enum logic [1:0] {
    CmdExec    = 2'd0,
    CmdPreload = 2'd1,
    CmdSetPc   = 2'd2,
    CmdIdle    = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    KindNone   = 4'd0,
    KindAdd    = 4'd1,
    KindSub    = 4'd2,
    KindAnd    = 4'd3,
    KindOr     = 4'd4,
    KindXor    = 4'd5,
    KindLoad   = 4'd6,
    KindStore  = 4'd7,
    KindBranch = 4'd8,
    KindJump   = 4'd9
  } op_kind_e;

  // major opcodes, bits 6:0
  localparam logic [6:0] OpcRtype  = 7'b1001111;
  localparam logic [6:0] OpcLoad   = 7'b1101111;
  localparam logic [6:0] OpcStore  = 7'b0100011;
  localparam logic [6:0] OpcBranch = 7'b1100011;
  localparam logic [6:0] OpcJump   = 7'b1101110;

  // r-type function fields
  localparam logic [6:0] F7Base  = 7'b0000000;
  localparam logic [6:0] F7Logic = 7'b0000001;
  localparam logic [6:0] F7Sub   = 7'b0100000;
  localparam logic [2:0] F3Wide  = 3'b111;
  localparam logic [2:0] F3Or    = 3'b110;
  localparam logic [2:0] F3Xor   = 3'b100;

  // branch conditions
  localparam logic [2:0] F3Beq = 3'b000;
  localparam logic [2:0] F3Bne = 3'b001;

  typedef struct packed {
    cmd_e               cmd;
    logic [31:0]        instr_word;
    logic [4:0]         preload_addr;
    logic signed [31:0] preload_data;
    logic [4:0]         new_pc;
  } in_req_t;

  typedef struct packed {
    logic [4:0]         next_pc;
    op_kind_e           op_kind;
    logic               branch_taken;
    logic               store_done;
    logic [4:0]         store_index;
    logic signed [31:0] store_value;
    logic               bad_address;
  } out_rsp_t;

  // register file contents after reset
  function automatic logic [31:0] rf_reset_val(input logic [RegIdxW-1:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:    val = 32'd111;
      5'd1:    val = 32'd111;
      5'd3:    val = 32'd3;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/trx_ram.sv =====
// trx_ram: generic simple dual port ram, one write and one registered read port
// read returns the old word on a same-cycle write; no dependencies
`default_nettype none

module trx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic                             re_i,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tiny_riscv_like_execute_core.sv =====
// tiny_riscv_like_execute_core: single pass execute core with register file and data store
// uses trx_pkg (types, codes) and trx_ram (register file copies, data store)
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+----------------------
//   request | in_valid_i  | in_stall_o  | in_req_i  (in_req_t)
//   result  | out_valid_o | out_stall_i | out_rsp_o (out_rsp_t)
//
// one request is taken per cycle unless stalled; its result sits in the output register
// the execute register and the output register part the sides, so a waiting result does
// not hold off the next request unless the output register is still full and stalled
// after reset the data store is swept to zero, one word per cycle, all DMEM_WORDS words,
// with in_stall_o high; the register file uses per-entry valid bits instead
// register file writes land in the cycle after execute, forwarded to the next request
`default_nettype none

module tiny_riscv_like_execute_core
  import trx_pkg::*;
#(
  parameter int DMEM_WORDS = 32,
  parameter int IMEM_WORDS = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_req_t  in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_rsp_t      out_rsp_o
);

  // pc and data store index widths
  localparam int PW = $clog2(IMEM_WORDS);
  localparam int AW = $clog2(DMEM_WORDS);

  // pc offsets are reduced modulo IMEM_WORDS with a reciprocal multiply;
  // the offset is biased to be non-negative and fits in WW bits
  localparam int WW = 23;
  localparam int SH = WW + PW;
  localparam int RW = 25;
  localparam longint unsigned Recip = ((64'd1 << SH) + IMEM_WORDS - 1) / IMEM_WORDS;
  localparam int Bias = IMEM_WORDS * ((2 ** 21 + IMEM_WORDS - 1) / IMEM_WORDS);
  localparam logic [PW:0]    ImemN   = (PW + 1)'(IMEM_WORDS);
  localparam logic [AW-1:0]  ClrLast = AW'(DMEM_WORDS - 1);
  localparam logic [33:0]    DmemN   = 34'(DMEM_WORDS);

  // handshake
  logic acc;
  logic a_adv;

  // request side pre-decode: pc offset or new pc, reduced
  logic [6:0]           in_opc;
  logic [RegIdxW-1:0]   in_ra;
  logic [RegIdxW-1:0]   in_rb;
  logic [12:0]          in_boff;
  logic [20:0]          in_joff;
  logic signed [23:0]   in_off2;
  logic [23:0]          in_wb24;
  logic [WW-1:0]        in_w;
  logic [47:0]          in_prod;

  // execute register
  logic                 a_valid_q;
  in_req_t              a_q;
  logic [WW-1:0]        a_w_q;
  logic [WW-1:0]        a_quot_q;
  logic                 rv_a_q, rv_b_q;
  logic                 pat_a_vld_q, pat_b_vld_q;
  logic [31:0]          pat_a_q, pat_b_q;

  // register file valid bits, pc, clear sweep
  logic [RegCount-1:0]  vld_q;
  logic [PW-1:0]        pc_q;
  logic                 clr_busy_q;
  logic [AW-1:0]        clr_cnt_q;

  // write-back register (loaded as execute advances)
  logic                 wb_valid_q;
  logic [RegIdxW-1:0]   wb_rd_q;
  logic                 wb_load_q;
  logic [31:0]          wb_data_q;
  logic [31:0]          wb_val;

  // output register
  logic                 out_valid_q;
  out_rsp_t             out_q;

  // ram ports
  logic [31:0]          rfa_rdata, rfb_rdata, dm_rdata;
  logic                 dm_we;
  logic [AW-1:0]        dm_waddr;
  logic [31:0]          dm_wdata;

  // execute datapath
  logic [6:0]           opc;
  logic [6:0]           f7;
  logic [2:0]           f3;
  logic [RegIdxW-1:0]   rd, ra, rb;
  logic                 hit_wa, hit_wb;
  logic [31:0]          opa, opb;
  logic [32:0]          rem33;
  logic [PW-1:0]        r_mod;
  logic [PW:0]          pc_inc, pc_sum;
  logic [PW-1:0]        pc_seq, pc_tgt;
  logic [33:0]          mem_imm, mem_addr, dm_addr;
  logic                 dm_ok;
  logic [31:0]          ex_pc_ext;

  // execute outputs
  out_rsp_t             res;
  logic [PW-1:0]        pc_d;
  logic                 rd_we;
  logic [31:0]          rd_val;
  logic                 ld_re;
  logic                 ex_dm_we;

  // ---------------------------------------------------------------------------
  // handshake: execute register advances when the output register is free or drains
  // ---------------------------------------------------------------------------
  assign a_adv       = a_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = clr_busy_q || (a_valid_q && !a_adv);
  assign acc         = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // ---------------------------------------------------------------------------
  // request side: select pc offset (branch or jump) or new pc, then divide by
  // IMEM_WORDS; the remainder is finished in execute
  // ---------------------------------------------------------------------------
  assign in_opc  = in_req_i.instr_word[6:0];
  assign in_ra   = in_req_i.instr_word[24:20];
  assign in_rb   = in_req_i.instr_word[19:15];
  assign in_boff = {in_req_i.instr_word[31], in_req_i.instr_word[7],
                    in_req_i.instr_word[30:25], in_req_i.instr_word[11:8], 1'b0};
  assign in_joff = {in_req_i.instr_word[31], in_req_i.instr_word[19:12],
                    in_req_i.instr_word[20], in_req_i.instr_word[30:21], 1'b0};

  always_comb begin
    if (in_opc == OpcJump) begin
      in_off2 = {{2{in_joff[20]}}, in_joff, 1'b0};
    end else begin
      in_off2 = {{10{in_boff[12]}}, in_boff, 1'b0};
    end
    in_wb24 = in_off2 + 24'(Bias);
    if (in_req_i.cmd == CmdSetPc) begin
      in_w = WW'(in_req_i.new_pc);
    end else begin
      in_w = in_wb24[WW-1:0];
    end
    in_prod = 48'(in_w) * 48'(RW'(Recip));
  end

  // ---------------------------------------------------------------------------
  // register file: two read copies, written from the write-back register
  // ---------------------------------------------------------------------------
  // load data comes straight from the data store read register
  assign wb_val = wb_load_q ? dm_rdata : wb_data_q;

  trx_ram #(
    .WIDTH (32),
    .DEPTH (RegCount)
  ) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (wb_valid_q),
    .waddr_i (wb_rd_q),
    .wdata_i (wb_val),
    .re_i    (acc),
    .raddr_i (in_ra),
    .rdata_o (rfa_rdata)
  );

  trx_ram #(
    .WIDTH (32),
    .DEPTH (RegCount)
  ) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (wb_valid_q),
    .waddr_i (wb_rd_q),
    .wdata_i (wb_val),
    .re_i    (acc),
    .raddr_i (in_rb),
    .rdata_o (rfb_rdata)
  );

  // ---------------------------------------------------------------------------
  // data store: clear sweep after reset, then stores/preloads write, loads read
  // ---------------------------------------------------------------------------
  always_comb begin
    if (clr_busy_q) begin
      dm_we    = 1'b1;
      dm_waddr = clr_cnt_q;
      dm_wdata = '0;
    end else begin
      dm_we    = a_adv && ex_dm_we;
      dm_waddr = dm_addr[AW-1:0];
      dm_wdata = (a_q.cmd == CmdPreload) ? a_q.preload_data : opa;
    end
  end

  trx_ram #(
    .WIDTH (32),
    .DEPTH (DMEM_WORDS)
  ) u_dmem (
    .clk_i   (clk_i),
    .we_i    (dm_we),
    .waddr_i (dm_waddr),
    .wdata_i (dm_wdata),
    .re_i    (a_adv && ld_re),
    .raddr_i (dm_addr[AW-1:0]),
    .rdata_o (dm_rdata)
  );

  // ---------------------------------------------------------------------------
  // execute: operand forwarding
  // priority: pending write-back, then writes seen while waiting, then reset value or ram
  // ---------------------------------------------------------------------------
  assign opc = a_q.instr_word[6:0];
  assign f7  = a_q.instr_word[31:25];
  assign f3  = a_q.instr_word[14:12];
  assign rd  = a_q.instr_word[11:7];
  assign ra  = a_q.instr_word[24:20];
  assign rb  = a_q.instr_word[19:15];

  assign hit_wa = wb_valid_q && (wb_rd_q == ra);
  assign hit_wb = wb_valid_q && (wb_rd_q == rb);

  always_comb begin
    if (hit_wa) begin
      opa = wb_val;
    end else if (pat_a_vld_q) begin
      opa = pat_a_q;
    end else if (rv_a_q) begin
      opa = rfa_rdata;
    end else begin
      opa = rf_reset_val(ra);
    end
    if (hit_wb) begin
      opb = wb_val;
    end else if (pat_b_vld_q) begin
      opb = pat_b_q;
    end else if (rv_b_q) begin
      opb = rfb_rdata;
    end else begin
      opb = rf_reset_val(rb);
    end
  end

  // ---------------------------------------------------------------------------
  // execute: pc arithmetic, everything modulo IMEM_WORDS
  // ---------------------------------------------------------------------------
  assign rem33  = 33'(a_w_q) - 33'(a_quot_q) * 33'(IMEM_WORDS);
  assign r_mod  = rem33[PW-1:0];
  assign pc_inc = {1'b0, pc_q} + (PW + 1)'(1);
  assign pc_seq = (pc_inc == ImemN) ? '0 : pc_inc[PW-1:0];
  assign pc_sum = {1'b0, pc_q} + {1'b0, r_mod};

  always_comb begin
    if (pc_sum >= ImemN) begin
      pc_tgt = PW'(pc_sum - ImemN);
    end else begin
      pc_tgt = pc_sum[PW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // execute: data address, base plus signed offset without wrap
  // ---------------------------------------------------------------------------
  always_comb begin
    if (opc == OpcLoad) begin
      mem_imm = {{22{a_q.instr_word[31]}}, a_q.instr_word[31:20]};
    end else begin
      mem_imm = {{22{a_q.instr_word[31]}}, a_q.instr_word[31:25], a_q.instr_word[11:7]};
    end
    mem_addr = {{2{opb[31]}}, opb} + mem_imm;
    if (a_q.cmd == CmdPreload) begin
      dm_addr = 34'(a_q.preload_addr);
    end else begin
      dm_addr = mem_addr;
    end
    dm_ok = !dm_addr[33] && (dm_addr < DmemN);
  end

  // ---------------------------------------------------------------------------
  // execute: decode and result
  // ---------------------------------------------------------------------------
  always_comb begin
    res      = '0;
    pc_d     = pc_q;
    rd_we    = 1'b0;
    rd_val   = '0;
    ld_re    = 1'b0;
    ex_dm_we = 1'b0;
    case (a_q.cmd)
      CmdPreload: begin
        if (dm_ok) begin
          ex_dm_we        = 1'b1;
          res.store_done  = 1'b1;
          res.store_index = a_q.preload_addr;
          res.store_value = a_q.preload_data;
        end else begin
          res.bad_address = 1'b1;
        end
      end
      CmdSetPc: begin
        pc_d = r_mod;
      end
      CmdExec: begin
        pc_d = pc_seq;
        case (opc)
          OpcRtype: begin
            if (f7 == F7Base && f3 == F3Wide) begin
              res.op_kind = KindAdd;
              rd_we       = 1'b1;
              rd_val      = opa + opb;
            end else if (f7 == F7Sub && f3 == F3Wide) begin
              res.op_kind = KindSub;
              rd_we       = 1'b1;
              rd_val      = opa - opb;
            end else if (f7 == F7Logic && f3 == F3Wide) begin
              res.op_kind = KindAnd;
              rd_we       = 1'b1;
              rd_val      = opa & opb;
            end else if (f7 == F7Logic && f3 == F3Or) begin
              res.op_kind = KindOr;
              rd_we       = 1'b1;
              rd_val      = opa | opb;
            end else if (f7 == F7Logic && f3 == F3Xor) begin
              res.op_kind = KindXor;
              rd_we       = 1'b1;
              rd_val      = opa ^ opb;
            end
          end
          OpcLoad: begin
            // out of range load writes zero
            res.op_kind = KindLoad;
            rd_we       = 1'b1;
            if (dm_ok) begin
              ld_re = 1'b1;
            end else begin
              res.bad_address = 1'b1;
            end
          end
          OpcStore: begin
            res.op_kind = KindStore;
            if (dm_ok) begin
              ex_dm_we        = 1'b1;
              res.store_done  = 1'b1;
              res.store_index = dm_addr[4:0];
              res.store_value = opa;
            end else begin
              res.bad_address = 1'b1;
            end
          end
          OpcBranch: begin
            res.op_kind = KindBranch;
            if ((f3 == F3Beq && opa == opb) || (f3 == F3Bne && opa != opb)) begin
              res.branch_taken = 1'b1;
              pc_d             = pc_tgt;
            end
          end
          OpcJump: begin
            res.op_kind      = KindJump;
            res.branch_taken = 1'b1;
            pc_d             = pc_tgt;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    ex_pc_ext   = 32'(pc_d);
    res.next_pc = ex_pc_ext[4:0];
  end

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      pat_a_vld_q <= 1'b0;
      pat_b_vld_q <= 1'b0;
      vld_q       <= '0;
      pc_q        <= '0;
      clr_busy_q  <= 1'b1;
      clr_cnt_q   <= '0;
      wb_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // clear sweep of the data store
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
        if (clr_cnt_q == ClrLast) begin
          clr_busy_q <= 1'b0;
        end
      end

      // execute register occupancy
      if (acc) begin
        a_valid_q <= 1'b1;
      end else if (a_adv) begin
        a_valid_q <= 1'b0;
      end

      // track writes the register file ram read did not see
      if (acc) begin
        pat_a_vld_q <= wb_valid_q && (wb_rd_q == in_ra);
        pat_b_vld_q <= wb_valid_q && (wb_rd_q == in_rb);
      end else if (a_valid_q) begin
        if (hit_wa) begin
          pat_a_vld_q <= 1'b1;
        end
        if (hit_wb) begin
          pat_b_vld_q <= 1'b1;
        end
      end

      // register file write-back
      if (wb_valid_q) begin
        vld_q[wb_rd_q] <= 1'b1;
      end
      wb_valid_q <= a_adv && rd_we;

      if (a_adv) begin
        pc_q <= pc_d;
      end

      // output register
      if (a_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (acc) begin
      a_q      <= in_req_i;
      a_w_q    <= in_w;
      // quotient is the product above the shift, never past its top bit
      a_quot_q <= WW'(in_prod[47:SH]);
      rv_a_q   <= vld_q[in_ra];
      rv_b_q   <= vld_q[in_rb];
      pat_a_q  <= wb_val;
      pat_b_q  <= wb_val;
    end else begin
      if (hit_wa) begin
        pat_a_q <= wb_val;
      end
      if (hit_wb) begin
        pat_b_q <= wb_val;
      end
    end

    if (a_adv) begin
      wb_rd_q   <= rd;
      wb_load_q <= ld_re;
      wb_data_q <= rd_val;
      out_q     <= res;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tiny_riscv_like_execute_core_test.sv =====
// tiny_riscv_like_execute_core_test: self-checking bench for the execute core
// a directed script, then randomized requests checked against a cycle-free core predictor
// depends on trx_pkg and tiny_riscv_like_execute_core
`timescale 1ns / 100ps

module tiny_riscv_like_execute_core_test;
  import trx_pkg::*;

  localparam int DmemWords   = 32;
  localparam int RandomCount = 750;
  localparam int QuietLimit  = 2000;  // cycles with no handshake on either side
  localparam int HoldCycles  = 60;    // long result-side hold-off
  localparam int HoldAfter   = 170;   // requests taken before the hold-off starts
  localparam int DrainAt     = 500;   // random request index where the sender drains
  localparam int CalmFrom    = 300;   // stretch with no idling on either side
  localparam int CalmTo      = 450;
  localparam int IdlePercent = 22;

  // branch funct3 that is neither beq nor bne
  localparam logic [2:0] F3NoCond = 3'b111;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  in_req_t  in_req_i    = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_rsp_t out_rsp_o;

  tiny_riscv_like_execute_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // core state as the bench sees it
  logic [31:0] regs [32];
  logic [31:0] dmem [DmemWords];
  logic [4:0]  cur_pc;

  // results owed by the core, oldest first
  out_rsp_t pending_outcomes [$];
  int       mismatch_count = 0;
  int       requests_taken = 0;
  int       quiet_cycles   = 0;
  bit       calm_window    = 1'b0;

  typedef struct {
    in_req_t  req;
    bit       typed;
    out_rsp_t want;
  } script_row_t;

  script_row_t script [$];
  out_rsp_t    oldest;

  // ---------------------------------------------------------------------------
  // instruction encoders
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] enc_alu(input logic [6:0] f7, input logic [2:0] f3,
                                          input logic [4:0] rd, ra, rb);
    return {f7, ra, rb, f3, rd, OpcRtype};
  endfunction

  // funct3 is a don't-care for load and store, so it is randomized
  function automatic logic [31:0] enc_load(input logic [4:0] rd, rb, input logic [11:0] off);
    logic [2:0] f3;
    f3 = 3'($urandom);
    return {off, rb, f3, rd, OpcLoad};
  endfunction

  function automatic logic [31:0] enc_store(input logic [4:0] ra, rb, input logic [11:0] off);
    logic [2:0] f3;
    f3 = 3'($urandom);
    return {off[11:5], ra, rb, f3, off[4:0], OpcStore};
  endfunction

  function automatic logic [31:0] enc_branch(input logic [2:0] f3, input logic [4:0] ra, rb,
                                             input logic [12:0] off);
    return {off[12], off[10:5], ra, rb, f3, off[4:1], off[11], OpcBranch};
  endfunction

  // rd bits are unused by the jump and carry noise
  function automatic logic [31:0] enc_jump(input logic [20:0] off);
    logic [4:0] junk;
    junk = 5'($urandom);
    return {off[20], off[10:1], off[11], off[19:12], junk, OpcJump};
  endfunction

  function automatic in_req_t mk_req(input cmd_e c, input logic [31:0] iw,
                                     input logic [4:0] pa, input logic [31:0] pd,
                                     input logic [4:0] np);
    in_req_t r;
    r.cmd          = c;
    r.instr_word   = iw;
    r.preload_addr = pa;
    r.preload_data = pd;
    r.new_pc       = np;
    return r;
  endfunction

  function automatic in_req_t exec_req(input logic [31:0] iw);
    return mk_req(CmdExec, iw, 5'd0, 32'd0, 5'd0);
  endfunction

  function automatic out_rsp_t rsp(input logic [4:0] npc, input op_kind_e k, input logic t,
                                   input logic sd, input logic [4:0] si,
                                   input logic [31:0] sv, input logic bad);
    out_rsp_t o;
    o.next_pc      = npc;
    o.op_kind      = k;
    o.branch_taken = t;
    o.store_done   = sd;
    o.store_index  = si;
    o.store_value  = sv;
    o.bad_address  = bad;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // predictor: applies one request to the bench copy of the core state
  // ---------------------------------------------------------------------------

  function automatic out_rsp_t compute_outcome(input in_req_t r);
    out_rsp_t    o;
    logic [31:0] iw, a, b;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [12:0] boff;
    logic [20:0] joff;
    longint      base_v, off_v, addr;
    int          disp, target;
    iw     = r.instr_word;
    rd     = iw[11:7];
    f3     = iw[14:12];
    f7     = iw[31:25];
    a      = regs[iw[24:20]];
    b      = regs[iw[19:15]];
    base_v = $signed(b);
    o      = '0;
    target = int'(cur_pc) + 1;
    case (r.cmd)
      CmdPreload: begin
        // the preload index always fits the store at this size
        dmem[r.preload_addr] = r.preload_data;
        o.store_done  = 1'b1;
        o.store_index = r.preload_addr;
        o.store_value = r.preload_data;
      end
      CmdSetPc: cur_pc = r.new_pc;
      CmdExec: begin
        case (iw[6:0])
          OpcRtype: begin
            if (f7 == F7Base && f3 == F3Wide) begin
              o.op_kind = KindAdd;
              regs[rd] = a + b;
            end else if (f7 == F7Sub && f3 == F3Wide) begin
              o.op_kind = KindSub;
              regs[rd] = a - b;
            end else if (f7 == F7Logic && f3 == F3Wide) begin
              o.op_kind = KindAnd;
              regs[rd] = a & b;
            end else if (f7 == F7Logic && f3 == F3Or) begin
              o.op_kind = KindOr;
              regs[rd] = a | b;
            end else if (f7 == F7Logic && f3 == F3Xor) begin
              o.op_kind = KindXor;
              regs[rd] = a ^ b;
            end
          end
          OpcLoad: begin
            off_v = $signed(iw[31:20]);
            addr  = base_v + off_v;
            o.op_kind = KindLoad;
            if (addr >= 0 && addr < DmemWords) begin
              regs[rd] = dmem[addr[4:0]];
            end else begin
              o.bad_address = 1'b1;
              regs[rd] = 32'd0;
            end
          end
          OpcStore: begin
            off_v = $signed({iw[31:25], iw[11:7]});
            addr  = base_v + off_v;
            o.op_kind = KindStore;
            if (addr >= 0 && addr < DmemWords) begin
              dmem[addr[4:0]] = a;
              o.store_done  = 1'b1;
              o.store_index = addr[4:0];
              o.store_value = a;
            end else begin
              o.bad_address = 1'b1;
            end
          end
          OpcBranch: begin
            boff = {iw[31], iw[7], iw[30:25], iw[11:8], 1'b0};
            o.op_kind = KindBranch;
            if ((f3 == F3Beq && a == b) || (f3 == F3Bne && a != b)) begin
              disp = $signed(boff);
              o.branch_taken = 1'b1;
              target = int'(cur_pc) + 2 * disp;
            end
          end
          OpcJump: begin
            joff = {iw[31], iw[19:12], iw[20], iw[30:21], 1'b0};
            disp = $signed(joff);
            o.op_kind = KindJump;
            o.branch_taken = 1'b1;
            target = int'(cur_pc) + 2 * disp;
          end
          default: ;
        endcase
        // pc wraps modulo the 32-word instruction space
        cur_pc = target[4:0];
      end
      default: ;
    endcase
    o.next_pc = cur_pc;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // random request generation, steered by the current register contents
  // ---------------------------------------------------------------------------

  // prefer a base register holding a small value so that addresses can reach the store
  function automatic logic [4:0] pick_base();
    logic [4:0] idx;
    longint     v;
    idx = 5'($urandom);
    repeat (6) begin
      idx = 5'($urandom);
      v = $signed(regs[idx]);
      if (v > -1024 && v < 1024) return idx;
    end
    return idx;
  endfunction

  // mostly an offset that lands inside the store, otherwise anything
  function automatic logic [11:0] aim_offset(input logic [4:0] base);
    longint      val, off;
    logic [11:0] any;
    val = $signed(regs[base]);
    off = longint'($urandom_range(DmemWords - 1)) - val;
    any = 12'($urandom);
    if (off >= -2048 && off <= 2047 && $urandom_range(9) < 8) return off[11:0];
    return any;
  endfunction

  function automatic in_req_t random_request();
    in_req_t     r;
    int          sel;
    logic [4:0]  rd, ra, rb;
    logic [6:0]  f7;
    logic [2:0]  f3;
    logic [12:0] boff;
    logic [20:0] joff;
    // fields the command ignores still carry random bits
    r.cmd          = CmdExec;
    r.instr_word   = $urandom;
    r.preload_addr = 5'($urandom);
    r.preload_data = $urandom;
    r.new_pc       = 5'($urandom);
    rd   = 5'($urandom);
    ra   = 5'($urandom);
    rb   = 5'($urandom);
    f7   = 7'($urandom);
    f3   = 3'($urandom);
    boff = 13'($urandom);
    joff = 21'($urandom);
    sel  = $urandom_range(99);
    if (sel < 8) begin
      r.cmd = CmdPreload;
      // small words make good load/store bases later on
      if ($urandom_range(1) == 0) r.preload_data = $urandom_range(40);
    end else if (sel < 12) begin
      r.cmd = CmdSetPc;
    end else if (sel < 14) begin
      r.cmd = CmdIdle;
    end else if (sel < 20) begin
      // raw instruction word, mostly unknown encodings
    end else if (sel < 52) begin
      case ($urandom_range(5))
        0:       r.instr_word = enc_alu(F7Base, F3Wide, rd, ra, rb);
        1:       r.instr_word = enc_alu(F7Sub, F3Wide, rd, ra, rb);
        2:       r.instr_word = enc_alu(F7Logic, F3Wide, rd, ra, rb);
        3:       r.instr_word = enc_alu(F7Logic, F3Or, rd, ra, rb);
        4:       r.instr_word = enc_alu(F7Logic, F3Xor, rd, ra, rb);
        default: r.instr_word = enc_alu(f7, f3, rd, ra, rb);
      endcase
    end else if (sel < 68) begin
      rb = pick_base();
      r.instr_word = enc_load(rd, rb, aim_offset(rb));
    end else if (sel < 84) begin
      rb = pick_base();
      r.instr_word = enc_store(ra, rb, aim_offset(rb));
    end else if (sel < 95) begin
      sel = $urandom_range(9);
      if (sel < 4) f3 = F3Beq;
      else if (sel < 8) f3 = F3Bne;
      // same register on both sides forces equality
      if ($urandom_range(2) == 0) rb = ra;
      r.instr_word = enc_branch(f3, ra, rb, boff);
    end else begin
      r.instr_word = enc_jump(joff);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request side: offered at the falling edge, taken at a rising edge without stall
  // ---------------------------------------------------------------------------

  task automatic offer(input in_req_t r, input bit typed, input out_rsp_t want);
    out_rsp_t predicted;
    while (!calm_window && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // the predictor always runs so that its state follows the core
    predicted = compute_outcome(r);
    pending_outcomes.push_back(typed ? want : predicted);
    requests_taken++;
    @(negedge clk_i);
  endtask

  // result side stall: random, quiet in the calm window, one long hold-off
  initial begin : result_sink
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && requests_taken >= HoldAfter) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        // the sender keeps offering, so the core fills up and stalls its input
        repeat (HoldCycles) @(negedge clk_i);
      end else begin
        out_stall_i <= !calm_window && ($urandom_range(99) < IdlePercent);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string fname, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want_v, got_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_rsp_o);
        mismatch_count++;
      end else begin
        oldest = pending_outcomes.pop_front();
        check_field("next_pc", oldest.next_pc, out_rsp_o.next_pc);
        check_field("op_kind", oldest.op_kind, out_rsp_o.op_kind);
        check_field("branch_taken", oldest.branch_taken, out_rsp_o.branch_taken);
        check_field("store_done", oldest.store_done, out_rsp_o.store_done);
        check_field("store_index", oldest.store_index, out_rsp_o.store_index);
        check_field("store_value", oldest.store_value, out_rsp_o.store_value);
        check_field("bad_address", oldest.bad_address, out_rsp_o.bad_address);
      end
    end
  end

  // watchdog on handshake activity, covers the store clearing pass after reset
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : main_seq
    // reset state of the predictor
    foreach (regs[i]) regs[i] = 32'd0;
    foreach (dmem[i]) dmem[i] = 32'd0;
    regs[0] = 32'd111;
    regs[1] = 32'd111;
    regs[3] = 32'd3;
    cur_pc  = 5'd0;

    // directed script, typed results where obvious
    // idle command right after reset
    script.push_back('{mk_req(CmdIdle, 32'd0, 5'd0, 32'd0, 5'd0), 1'b1,
                       rsp(5'd0, KindNone, 1'b0, 1'b0, 5'd0, 32'd0, 1'b0)});
    // preload the extreme words at both ends of the store
    script.push_back('{mk_req(CmdPreload, 32'd0, 5'd31, 32'h8000_0000, 5'd0), 1'b1,
                       rsp(5'd0, KindNone, 1'b0, 1'b1, 5'd31, 32'h8000_0000, 1'b0)});
    script.push_back('{mk_req(CmdPreload, 32'd0, 5'd0, 32'h7fff_ffff, 5'd0), 1'b1,
                       rsp(5'd0, KindNone, 1'b0, 1'b1, 5'd0, 32'h7fff_ffff, 1'b0)});
    // pc to the top, then a no-op wraps it to zero
    script.push_back('{mk_req(CmdSetPc, 32'd0, 5'd0, 32'd0, 5'd31), 1'b1,
                       rsp(5'd31, KindNone, 1'b0, 1'b0, 5'd0, 32'd0, 1'b0)});
    script.push_back('{exec_req(32'd0), 1'b1,
                       rsp(5'd0, KindNone, 1'b0, 1'b0, 5'd0, 32'd0, 1'b0)});
    // all-ones word is an unknown opcode
    script.push_back('{exec_req(32'hffff_ffff), 1'b1,
                       rsp(5'd1, KindNone, 1'b0, 1'b0, 5'd0, 32'd0, 1'b0)});
    // every alu op; r0 is written like any other register
    script.push_back('{exec_req(enc_alu(F7Base, F3Wide, 5'd2, 5'd1, 5'd0)), 1'b0, '0});
    script.push_back('{exec_req(enc_alu(F7Sub, F3Wide, 5'd4, 5'd3, 5'd2)), 1'b0, '0});
    script.push_back('{exec_req(enc_alu(F7Logic, F3Wide, 5'd5, 5'd4, 5'd1)), 1'b0, '0});
    script.push_back('{exec_req(enc_alu(F7Logic, F3Or, 5'd0, 5'd3, 5'd3)), 1'b0, '0});
    script.push_back('{exec_req(enc_alu(F7Logic, F3Xor, 5'd6, 5'd4, 5'd5)), 1'b0, '0});
    // unknown alu function
    script.push_back('{exec_req(enc_alu(F7Sub, F3Or, 5'd7, 5'd1, 5'd1)), 1'b0, '0});
    // loads: top word, out of range high, negative offset to word zero
    script.push_back('{exec_req(enc_load(5'd8, 5'd3, 12'd28)), 1'b0, '0});
    script.push_back('{exec_req(enc_load(5'd9, 5'd1, 12'h7ff)), 1'b0, '0});
    script.push_back('{exec_req(enc_load(5'd10, 5'd3, 12'hffd)), 1'b0, '0});
    // stores: in range, r0 as data, out of range low with the most negative offset
    script.push_back('{exec_req(enc_store(5'd8, 5'd3, 12'd2)), 1'b0, '0});
    script.push_back('{exec_req(enc_store(5'd0, 5'd0, 12'd1)), 1'b0, '0});
    script.push_back('{exec_req(enc_store(5'd10, 5'd1, 12'h800)), 1'b0, '0});
    // branches both ways with extreme offsets, and an undefined condition
    script.push_back('{exec_req(enc_branch(F3Beq, 5'd9, 5'd7, 13'h1000)), 1'b0, '0});
    script.push_back('{exec_req(enc_branch(F3Bne, 5'd9, 5'd7, 13'h0ffe)), 1'b0, '0});
    script.push_back('{exec_req(enc_branch(F3Bne, 5'd1, 5'd3, 13'd6)), 1'b0, '0});
    script.push_back('{exec_req(enc_branch(F3Beq, 5'd1, 5'd3, 13'd8)), 1'b0, '0});
    script.push_back('{exec_req(enc_branch(F3NoCond, 5'd9, 5'd7, 13'd4)), 1'b0, '0});
    // jumps with the largest forward and backward reach
    script.push_back('{exec_req(enc_jump(21'h0ffffe)), 1'b0, '0});
    script.push_back('{exec_req(enc_jump(21'h100000)), 1'b0, '0});
    script.push_back('{mk_req(CmdSetPc, 32'd0, 5'd0, 32'd0, 5'd0), 1'b0, '0});

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) offer(script[i].req, script[i].typed, script[i].want);

    for (int n = 0; n < RandomCount; n++) begin
      calm_window = (n >= CalmFrom && n < CalmTo);
      if (n == DrainAt) begin
        // sender pauses until every owed result has come back
        in_valid_i <= 1'b0;
        do @(negedge clk_i); while (pending_outcomes.size() != 0);
      end
      offer(random_request(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk_i);
    // results pass through the execute and output registers; leave room for strays
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/trx_pkg.sv
hw/rtl/trx_ram.sv
hw/rtl/tiny_riscv_like_execute_core.sv
tb/sv/tiny_riscv_like_execute_core_test.sv
